### src/assert_macros.svh
// Assertion macros shared by the dispatch table RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define PTD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define PTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/ptd_pkg.sv
// Types and constants of the periodic task dispatch table.
// No dependencies; imported by the controller, datapath and top level.
package ptd_pkg;

  localparam int ID_W     = 8;
  localparam int TICK_W   = 32;
  localparam int MS_W     = 32;
  localparam int PERIOD_W = 29;
  localparam int PROD_W   = 64;

  // x / 10 == (x * 0xCCCCCCCD) >> 35 for every 32-bit x
  localparam logic [MS_W-1:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int              DIV10_SHIFT = 35;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_DISPATCH = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_RUN      = 3'd0,
    KIND_DONE     = 3'd1,
    KIND_ADD_OK   = 3'd2,
    KIND_ADD_FULL = 3'd3,
    KIND_ACK      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_WALK,
    ST_COMPACT
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [TICK_W-1:0]   due;
    logic [PERIOD_W-1:0] period;
  } entry_t;

  typedef struct packed {
    logic  latch_add;
    logic  add_write;
    logic  tick_inc;
    logic  clear_all;
    logic  walk_init;
    logic  walk_step;
    logic  compact_init;
    logic  compact_step;
    logic  compact_done;
    logic  emit;
    kind_t emit_kind;
  } ptd_cmd_t;

  typedef struct packed {
    logic full;
    logic walk_end;
    logic any_kill;
    logic compact_end;
  } ptd_stat_t;

endpackage

### src/ptd_ctrl.sv
// Controller state machine of the dispatch table.
// Depends on ptd_pkg; drives the datapath through ptd_cmd_t.
module ptd_ctrl import ptd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic [1:0] in_cmd,
  input  ptd_stat_t stat,
  output ptd_cmd_t  cmd,
  output logic      busy
);

  state_t state_r, state_nxt;
  cmd_t   op;

  assign op   = cmd_t'(in_cmd);
  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (op)
            CMD_ADD:      if (!stat.full) state_nxt = ST_ADD_WR;
            CMD_DISPATCH: state_nxt = ST_WALK;
            CMD_TICK:     state_nxt = ST_IDLE;
            CMD_CLEAR:    state_nxt = ST_IDLE;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD_WR: state_nxt = ST_IDLE;
      ST_WALK: begin
        if (stat.walk_end) state_nxt = stat.any_kill ? ST_COMPACT : ST_IDLE;
      end
      ST_COMPACT: begin
        if (stat.compact_end) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.emit_kind = KIND_ACK;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (op)
            CMD_ADD: begin
              if (stat.full) begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = KIND_ADD_FULL;
              end else begin
                cmd.latch_add = 1'b1;
              end
            end
            CMD_TICK: begin
              cmd.tick_inc = 1'b1;
              cmd.emit     = 1'b1;
            end
            CMD_DISPATCH: cmd.walk_init = 1'b1;
            CMD_CLEAR: begin
              cmd.clear_all = 1'b1;
              cmd.emit      = 1'b1;
            end
            default: cmd = '0;
          endcase
        end
      end
      ST_ADD_WR: begin
        cmd.add_write = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_kind = KIND_ADD_OK;
      end
      ST_WALK: begin
        if (stat.walk_end) begin
          cmd.emit         = 1'b1;
          cmd.emit_kind    = KIND_DONE;
          cmd.compact_init = stat.any_kill;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_COMPACT: begin
        if (stat.compact_end) cmd.compact_done = 1'b1;
        else                  cmd.compact_step = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### src/ptd_dp.sv
// Datapath of the dispatch table: entry memory, tick counter, walk and
// compaction pointers, divide-by-ten multiplier, result register. Uses ptd_pkg.
module ptd_dp import ptd_pkg::*; #(
  parameter int TASKS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ptd_cmd_t            cmd,
  input  logic [ID_W-1:0]     in_task_id,
  input  logic [TICK_W-1:0]   in_start_tick,
  input  logic [MS_W-1:0]     in_period_ms,
  output ptd_stat_t           stat,
  output logic                out_valid,
  output logic [2:0]          out_kind,
  output logic [ID_W-1:0]     out_run_id,
  output logic                out_last
);

  localparam int CNT_W = $clog2(TASKS + 1);
  localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;

  entry_t entry_mem [TASKS];
  entry_t mem_q_r;
  entry_t mem_wdata;
  logic   mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;

  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic              vld_r, vld_nxt;
  logic [TASKS-1:0]  kill_r, kill_nxt;
  logic              any_kill_r, any_kill_nxt;

  logic [ID_W-1:0]   add_id_r;
  logic [TICK_W-1:0] add_due_r;
  logic [PROD_W-1:0] prod_r;

  logic              ov_r, ov_nxt;
  kind_t             kind_r, kind_nxt;
  logic [ID_W-1:0]   rid_r, rid_nxt;
  logic              last_r, last_nxt;

  logic [CNT_W-1:0]  rd_dec;
  logic              is_due;
  entry_t            resched;

  assign rd_dec  = rd_ptr_r - CNT_W'(1);
  assign is_due  = (mem_q_r.due <= tick_r);
  always_comb begin
    resched     = mem_q_r;
    resched.due = tick_r + TICK_W'(mem_q_r.period);
  end

  assign stat.full        = (count_r == CNT_W'(TASKS));
  assign stat.walk_end    = (rd_ptr_r == '0) && !vld_r;
  assign stat.any_kill    = any_kill_r;
  assign stat.compact_end = (rd_ptr_r == count_r) && !vld_r;

  always_comb begin
    tick_nxt     = tick_r;
    count_nxt    = count_r;
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    pos_nxt      = pos_r;
    vld_nxt      = 1'b0;
    kill_nxt     = kill_r;
    any_kill_nxt = any_kill_r;
    mem_we       = 1'b0;
    mem_waddr    = count_r[IDX_W-1:0];
    mem_wdata    = '{id: add_id_r, due: add_due_r,
                     period: prod_r[DIV10_SHIFT +: PERIOD_W]};
    mem_raddr    = rd_dec[IDX_W-1:0];
    ov_nxt       = cmd.emit;
    kind_nxt     = cmd.emit_kind;
    rid_nxt      = '0;
    last_nxt     = 1'b1;

    if (cmd.tick_inc) tick_nxt = tick_r + TICK_W'(1);
    if (cmd.clear_all) begin
      tick_nxt  = '0;
      count_nxt = '0;
    end
    if (cmd.add_write) begin
      mem_we    = 1'b1;
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.walk_init) begin
      rd_ptr_nxt   = count_r;
      kill_nxt     = '0;
      any_kill_nxt = 1'b0;
    end
    if (cmd.walk_step) begin
      if (rd_ptr_r != '0) begin
        rd_ptr_nxt = rd_dec;
        pos_nxt    = rd_dec[IDX_W-1:0];
        vld_nxt    = 1'b1;
      end
      if (vld_r && is_due) begin
        ov_nxt   = 1'b1;
        kind_nxt = KIND_RUN;
        rid_nxt  = mem_q_r.id;
        last_nxt = 1'b0;
        if (mem_q_r.period != '0) begin
          mem_we    = 1'b1;
          mem_waddr = pos_r;
          mem_wdata = resched;
        end else begin
          kill_nxt[pos_r] = 1'b1;
          any_kill_nxt    = 1'b1;
        end
      end
    end
    if (cmd.compact_init) begin
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
    end
    if (cmd.compact_step) begin
      mem_raddr = rd_ptr_r[IDX_W-1:0];
      if (rd_ptr_r != count_r) begin
        rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
        pos_nxt    = rd_ptr_r[IDX_W-1:0];
        vld_nxt    = 1'b1;
      end
      if (vld_r && !kill_r[pos_r]) begin
        mem_we     = 1'b1;
        mem_waddr  = wr_ptr_r[IDX_W-1:0];
        mem_wdata  = mem_q_r;
        wr_ptr_nxt = wr_ptr_r + CNT_W'(1);
      end
    end
    if (cmd.compact_done) begin
      count_nxt    = wr_ptr_r;
      any_kill_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) entry_mem[mem_waddr] <= mem_wdata;
    mem_q_r <= entry_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_add) begin
      add_id_r  <= in_task_id;
      add_due_r <= in_start_tick;
      prod_r    <= PROD_W'(in_period_ms) * PROD_W'(DIV10_MAGIC);
    end
    pos_r  <= pos_nxt;
    kind_r <= kind_nxt;
    rid_r  <= rid_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r     <= '0;
      count_r    <= '0;
      rd_ptr_r   <= '0;
      wr_ptr_r   <= '0;
      vld_r      <= 1'b0;
      kill_r     <= '0;
      any_kill_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      tick_r     <= tick_nxt;
      count_r    <= count_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      vld_r      <= vld_nxt;
      kill_r     <= kill_nxt;
      any_kill_r <= any_kill_nxt;
      ov_r       <= ov_nxt;
    end
  end

  assign out_valid  = ov_r;
  assign out_kind   = kind_r;
  assign out_run_id = rid_r;
  assign out_last   = last_r;

endmodule

### src/periodic_task_dispatch_table.sv
// Periodic task dispatch table, top level.
// Depends on ptd_pkg, ptd_ctrl, ptd_dp and assert_macros.svh.
//
// Usage: a command is taken at a clock edge with start high and busy low.
// in_cmd selects add, tick, dispatch or clear; in_task_id, in_start_tick and
// in_period_ms are read only by add. Every result beat is shown for one cycle
// with out_valid high; the receiver cannot stall, and out_last marks the
// final beat of a command.
// Command sequences:
//   tick, clear, rejected add: result in the next cycle.
//   accepted add: divide-by-ten multiply, then table write.
//   dispatch: one entry per cycle through the registered read port of the
//   entry memory; run beats stream out, done beat last. If any run-once
//   entry fired, a compaction pass follows with busy high and no beats.
// Reset (rst_n low, synchronous) clears the counter and the entry count;
// the entry memory itself is not cleared.
`include "assert_macros.svh"

module periodic_task_dispatch_table import ptd_pkg::*; #(
  parameter int TASKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_task_id,
  input  logic [31:0] in_start_tick,
  input  logic [31:0] in_period_ms,
  output logic        out_valid,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_run_id,
  output logic        out_last
);

  ptd_cmd_t  cmd;
  ptd_stat_t stat;

  logic tick_acc;
  logic disp_acc;
  logic ack_beat;
  logic last_ok;

  ptd_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  ptd_dp #(
    .TASKS (TASKS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_task_id    (in_task_id),
    .in_start_tick (in_start_tick),
    .in_period_ms  (in_period_ms),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_run_id    (out_run_id),
    .out_last      (out_last)
  );

  assign tick_acc = start && !busy && (in_cmd == CMD_TICK);
  assign disp_acc = start && !busy && (in_cmd == CMD_DISPATCH);
  assign ack_beat = out_valid && (out_kind == KIND_ACK) && out_last;
  assign last_ok  = (out_last == (out_kind != KIND_RUN));

  `PTD_ASSERT(a_tick_ack, clk, rst_n, tick_acc |=> ack_beat, "tick not acknowledged")
  `PTD_ASSERT(a_last_kind, clk, rst_n, out_valid |-> last_ok, "last flag does not match kind")
  `PTD_ASSERT(a_disp_busy, clk, rst_n, disp_acc |=> busy, "dispatch did not hold busy")
  `PTD_ASSERT(a_compact_quiet, clk, rst_n, cmd.compact_step |=> !out_valid, "beat in compaction")

endmodule
